>>> rtl/core/dcam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcam_pkg;

  // Field widths
  localparam int SPEED_W    = 16;
  localparam int ACCEL_W    = 16;
  localparam int STEER_W    = 21;
  localparam int RATE_W     = 23;
  localparam int LIMIT_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int SRL_W      = 22;
  localparam int DLEN_W     = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Steering dead band, microradians
  localparam int STEER_DEADBAND = 100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_LIMIT      = 3'd0,
    REG_BRAKE_DECEL      = 3'd1,
    REG_SPEED_GAIN       = 3'd2,
    REG_STEER_RATE_LIMIT = 3'd3,
    REG_DELAY_LENGTH     = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/core/dcam_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dcam_in_if
  import dcam_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_target;
  logic signed [ACCEL_W-1:0] accel_target;
  logic signed [STEER_W-1:0] desired_steer;
  logic signed [SPEED_W-1:0] current_speed;
  logic signed [STEER_W-1:0] current_steer;

  modport source (
    output valid, speed_target, accel_target, desired_steer, current_speed, current_steer,
    input  ready
  );
  modport sink (
    input  valid, speed_target, accel_target, desired_steer, current_speed, current_steer,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/dcam_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dcam_out_if
  import dcam_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_cmd;
  logic signed [RATE_W-1:0]  steer_rate_cmd;
  logic signed [STEER_W-1:0] delayed_steer;

  modport source (
    output valid, accel_cmd, steer_rate_cmd, delayed_steer,
    input  ready
  );
  modport sink (
    input  valid, accel_cmd, steer_rate_cmd, delayed_steer,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/drive_command_actuator_model_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: an input transfer is registered in stage 1, then moves into the result register
//   that drives cmd_out once that register is empty or being drained.
// Throughput: one item per cycle; stage 1 holds the input item and the delay-line
//   read, the result register follows, and both stall only on cmd_out backpressure.
// Reset (rst, synchronous, active high): configuration registers return to their defaults,
//   the pipeline empties and the steering delay line restarts writing at entry zero.

module drive_command_actuator_model_unit
  import dcam_pkg::*;
#(
  parameter int DELAY_MAX = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  dcam_in_if.sink                    cmd_in,
  dcam_out_if.source                 cmd_out
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [LIMIT_W-1:0] accel_limit;
  logic [LIMIT_W-1:0] brake_decel;
  logic [GAIN_W-1:0]  speed_gain;
  logic [SRL_W-1:0]   steer_rate_limit;
  logic [DLEN_W-1:0]  delay_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit      <= LIMIT_W'(5000);
      brake_decel      <= LIMIT_W'(5000);
      speed_gain       <= GAIN_W'(512);
      steer_rate_limit <= SRL_W'(3200000);
      delay_length     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ACCEL_LIMIT:      accel_limit      <= cfg_wdata[LIMIT_W-1:0];
        REG_BRAKE_DECEL:      brake_decel      <= cfg_wdata[LIMIT_W-1:0];
        REG_SPEED_GAIN:       speed_gain       <= cfg_wdata[GAIN_W-1:0];
        REG_STEER_RATE_LIMIT: steer_rate_limit <= cfg_wdata[SRL_W-1:0];
        REG_DELAY_LENGTH:     delay_length     <= cfg_wdata[DLEN_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: stage 1 moves into the result register whenever that
  // register is empty or being drained this cycle.
  // ---------------------------------------------------------------------
  logic v1;
  logic adv;
  logic accept;

  assign adv          = !cmd_out.valid || cmd_out.ready;
  assign cmd_in.ready = !v1 || adv;
  assign accept       = cmd_in.valid && cmd_in.ready;

  // ---------------------------------------------------------------------
  // Stage 1: input register plus delay-line tap
  // ---------------------------------------------------------------------
  logic signed [SPEED_W-1:0] s1_dspeed;
  logic signed [ACCEL_W-1:0] s1_daccel;
  logic signed [SPEED_W-1:0] s1_cspeed;
  logic signed [STEER_W-1:0] s1_csteer;
  logic signed [STEER_W-1:0] s1_delayed;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dspeed <= cmd_in.speed_target;
      s1_daccel <= cmd_in.accel_target;
      s1_cspeed <= cmd_in.current_speed;
      s1_csteer <= cmd_in.current_steer;
    end
  end

  dcam_delay_line #(
    .DELAY_MAX (DELAY_MAX)
  ) u_delay (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .din          (cmd_in.desired_steer),
    .delay_length (delay_length),
    .delayed      (s1_delayed)
  );

  // ---------------------------------------------------------------------
  // Acceleration command
  // ---------------------------------------------------------------------
  logic signed [SPEED_W:0]     err;          // 17-bit speed error
  logic signed [2*SPEED_W+1:0] prod;         // gain (Q8.8) x error
  logic signed [2*SPEED_W-7:0] prop_raw;     // floor(prod / 256)
  logic signed [2*SPEED_W-7:0] prop_lim;
  logic signed [ACCEL_W-1:0]   prop_cmd;
  logic signed [ACCEL_W:0]     dacc_ext;
  logic signed [ACCEL_W:0]     dacc_lim;
  logic signed [ACCEL_W-1:0]   dacc_cmd;
  logic signed [ACCEL_W-1:0]   brake_cmd;
  logic                        err_pos;
  logic                        moving_fwd;
  logic                        moving_bwd;
  logic signed [ACCEL_W-1:0]   accel_next;

  always_comb begin
    err      = (SPEED_W+1)'(s1_dspeed) - (SPEED_W+1)'(s1_cspeed);
    prod     = (2*SPEED_W+2)'($signed({1'b0, speed_gain})) * (2*SPEED_W+2)'(err);
    prop_raw = $signed(prod[2*SPEED_W+1:8]);
    prop_lim = $signed((2*SPEED_W-6)'(accel_limit));
    if (prop_raw > prop_lim) begin
      prop_cmd = ACCEL_W'(prop_lim);
    end else if (prop_raw < -prop_lim) begin
      prop_cmd = ACCEL_W'(-prop_lim);
    end else begin
      prop_cmd = ACCEL_W'(prop_raw);
    end

    // Direct acceleration demand, clamped symmetrically
    dacc_ext = (ACCEL_W+1)'(s1_daccel);
    dacc_lim = $signed((ACCEL_W+1)'(accel_limit));
    if (dacc_ext > dacc_lim) begin
      dacc_cmd = ACCEL_W'(dacc_lim);
    end else if (dacc_ext < -dacc_lim) begin
      dacc_cmd = ACCEL_W'(-dacc_lim);
    end else begin
      dacc_cmd = s1_daccel;
    end

    brake_cmd  = $signed(ACCEL_W'(brake_decel));
    err_pos    = !err[SPEED_W] && (err != '0);
    moving_fwd = !s1_cspeed[SPEED_W-1] && (s1_cspeed != '0);
    moving_bwd = s1_cspeed[SPEED_W-1];

    // Zero error while moving forward still brakes; brake is not clamped.
    if (s1_daccel != '0) begin
      accel_next = dacc_cmd;
    end else if (moving_fwd) begin
      accel_next = err_pos ? prop_cmd : -brake_cmd;
    end else if (moving_bwd) begin
      accel_next = err_pos ? brake_cmd : prop_cmd;
    end else begin
      accel_next = prop_cmd;
    end
  end

  // ---------------------------------------------------------------------
  // Steering rate: bang-bang outside the dead band
  // ---------------------------------------------------------------------
  logic signed [STEER_W:0]  steer_diff;
  logic signed [RATE_W-1:0] rate_next;

  always_comb begin
    steer_diff = (STEER_W+1)'(s1_delayed) - (STEER_W+1)'(s1_csteer);
    if (steer_diff > (STEER_W+1)'(STEER_DEADBAND)) begin
      rate_next = $signed(RATE_W'(steer_rate_limit));
    end else if (steer_diff < -(STEER_W+1)'(STEER_DEADBAND)) begin
      rate_next = -$signed(RATE_W'(steer_rate_limit));
    end else begin
      rate_next = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out.valid <= 1'b0;
    end else if (adv) begin
      cmd_out.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      cmd_out.accel_cmd      <= accel_next;
      cmd_out.steer_rate_cmd <= rate_next;
      cmd_out.delayed_steer  <= s1_delayed;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted transfer did not reach stage 1");

  a_s1_holds_on_stall : assert property (@(posedge clk) disable iff (rst)
    (v1 && !adv) |=> (v1 && $stable(s1_daccel) && $stable(s1_delayed)))
    else $error("stage 1 lost its item while stalled");

  a_s1_drains_to_out : assert property (@(posedge clk) disable iff (rst)
    (v1 && adv) |=> cmd_out.valid)
    else $error("stage 1 item did not reach the result register");

endmodule

`default_nettype wire

>>> rtl/core/dcam_delay_line.sv
`timescale 1ns / 1ps
`default_nettype none

module dcam_delay_line
  import dcam_pkg::*;
#(
  parameter int DELAY_MAX = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire logic signed [STEER_W-1:0] din,
  input  wire logic [DLEN_W-1:0]         delay_length,
  output logic signed [STEER_W-1:0]      delayed
);

  localparam int PTR_W = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
  localparam int LEN_W = ($clog2(DELAY_MAX + 1) > DLEN_W) ? $clog2(DELAY_MAX + 1) : DLEN_W;
  localparam int SUM_W = LEN_W + 1;

  logic [STEER_W-1:0] mem [DELAY_MAX];

  logic [PTR_W-1:0]   ptr;
  logic               wrapped;   // every entry written at least once

  logic [LEN_W-1:0]   len_ext;
  logic [LEN_W-1:0]   len;
  logic [SUM_W-1:0]   rd_sum;
  logic [SUM_W-1:0]   rd_wrap;
  logic [PTR_W-1:0]   rd_addr;
  logic               tap_ok;
  logic               ptr_last;

  logic [STEER_W-1:0] mem_q;
  logic [STEER_W-1:0] din_q;
  logic               bypass_q;
  logic               tap_ok_q;

  // Read position: len entries behind the write pointer, modulo depth.
  always_comb begin
    len_ext  = LEN_W'(delay_length);
    len      = (len_ext > LEN_W'(DELAY_MAX)) ? LEN_W'(DELAY_MAX) : len_ext;
    rd_sum   = SUM_W'(ptr) + SUM_W'(DELAY_MAX) - SUM_W'(len);
    rd_wrap  = (rd_sum >= SUM_W'(DELAY_MAX)) ? (rd_sum - SUM_W'(DELAY_MAX)) : rd_sum;
    rd_addr  = rd_wrap[PTR_W-1:0];
    // Entries are filled in order from zero, so an entry below the pointer
    // or any entry after the first wrap holds written data.
    tap_ok   = wrapped || (rd_addr < ptr);
    ptr_last = (ptr == PTR_W'(DELAY_MAX - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      wrapped <= 1'b0;
    end else if (push) begin
      ptr     <= ptr_last ? '0 : ptr + PTR_W'(1);
      wrapped <= wrapped | ptr_last;
    end
  end

  // Read-first: the tap sees the old entry when read and write addresses meet.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[ptr] <= din;
      mem_q    <= mem[rd_addr];
      din_q    <= din;
      bypass_q <= (len == '0);
      tap_ok_q <= tap_ok;
    end
  end

  always_comb begin
    if (bypass_q) begin
      delayed = din_q;
    end else if (tap_ok_q) begin
      delayed = mem_q;
    end else begin
      delayed = '0;
    end
  end

endmodule

`default_nettype wire
